>>> rtl/core/pmg_pkg.sv
// Shared types, constants and the saturation helper of the point-mass gravity step.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pmg_pkg;

  localparam int ValueW   = 32;
  localparam int FracBits = 16;

  // Floor division of a 32-bit magnitude by ten as a reciprocal multiply.
  localparam logic [31:0] Div10Magic = 32'hCCCC_CCCD;
  localparam int          Div10Shift = 35;
  localparam int          Quo10W     = 64 - Div10Shift;

  localparam logic [31:0] TimeStepReset = 32'h0001_0000;

  localparam int DivSteps  = 64;
  localparam int DivCntW   = 6;
  localparam int RootSteps = 30;
  localparam int RootCntW  = 5;
  localparam int RootW     = 30;
  localparam int RadW      = 2 * RootW;
  localparam int ClampW    = 66;

  typedef enum logic [1:0] {
    ACT_ATTRACT = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_PLACE   = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    LOP_NONE  = 4'd0,
    LOP_DIFF  = 4'd1,
    LOP_DIV10 = 4'd2,
    LOP_SQ    = 4'd3,
    LOP_UDIV  = 4'd4,
    LOP_MUL0  = 4'd5,
    LOP_MUL1  = 4'd6,
    LOP_MUL2  = 4'd7,
    LOP_CLAMP = 4'd8,
    LOP_ADV0  = 4'd9,
    LOP_ADV1  = 4'd10,
    LOP_ADV2  = 4'd11,
    LOP_ADV3  = 4'd12,
    LOP_PLACE = 4'd13
  } lane_op_e;

  typedef struct packed {
    logic busy;
    logic sat;
  } lane_stat_t;

  typedef struct packed {
    logic [ValueW-1:0] val;
    logic              sat;
  } clamp_t;

  // Clamps a two's complement value to the signed 32-bit range.
  function automatic clamp_t clamp32(input logic [ClampW-1:0] v);
    clamp_t res;
    logic   fits;
    fits = (v[ClampW-1:ValueW-1] == '0) || (v[ClampW-1:ValueW-1] == '1);
    res.sat = !fits;
    if (fits) begin
      res.val = v[ValueW-1:0];
    end else if (v[ClampW-1]) begin
      res.val = {1'b1, {(ValueW-1){1'b0}}};
    end else begin
      res.val = {1'b0, {(ValueW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pmg_if.sv
// Channel interfaces of the point-mass gravity step: items, results and configuration.
// Depends on pmg_pkg for the value width.
`default_nettype none

interface pmg_in_if;
  import pmg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [ValueW-1:0] other_x;
  logic signed [ValueW-1:0] other_y;
  logic [ValueW-1:0]        other_mass;
  modport source (output valid, action, other_x, other_y, other_mass, input ready);
  modport sink (input valid, action, other_x, other_y, other_mass, output ready);
endinterface

interface pmg_out_if;
  import pmg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] pos_x;
  logic signed [ValueW-1:0] pos_y;
  logic signed [ValueW-1:0] vel_x;
  logic signed [ValueW-1:0] vel_y;
  logic signed [ValueW-1:0] acc_x;
  logic signed [ValueW-1:0] acc_y;
  logic                     coincident;
  logic                     saturated;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, coincident,
                  saturated, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, coincident,
                saturated, output ready);
endinterface

interface pmg_cfg_if;
  import pmg_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pmg_divider.sv
// Iterative restoring divider, one quotient bit per cycle, 64 quotient bits per division.
// Depends on pmg_pkg for step counts.
`default_nettype none

module pmg_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [59:0] den_i,
  output logic             busy_o,
  output logic [63:0]      quo_o
);
  import pmg_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [63:0]        num_q, num_d;
  logic [63:0]        quo_q, quo_d;
  logic [59:0]        rem_q, rem_d;
  logic [59:0]        den_q, den_d;
  logic [60:0]        cand;
  logic [60:0]        diff;
  logic               ge;

  always_comb begin
    cand   = {rem_q, num_q[63]};
    diff   = cand - {1'b0, den_q};
    ge     = cand >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[59:0] : cand[59:0];
      num_d = {num_q[62:0], 1'b0};
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/pmg_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on pmg_pkg for widths and step counts.
`default_nettype none

module pmg_isqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pmg_pkg::RadW-1:0]   rad_i,
  output logic                            busy_o,
  output logic [pmg_pkg::RootW-1:0]       root_o
);
  import pmg_pkg::*;

  logic                busy_q, busy_d;
  logic [RootCntW-1:0] cnt_q, cnt_d;
  logic [RadW-1:0]     rad_q, rad_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [RootW:0]      rem_q, rem_d;
  logic [RootW+2:0]    cand;
  logic [RootW+2:0]    trial;
  logic [RootW+2:0]    diff;
  logic                ge;

  always_comb begin
    cand   = {rem_q, rad_q[RadW-1:RadW-2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = cand - trial;
    ge     = cand >= trial;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      // The remainder never exceeds twice the partial root, so it fits RootW+1 bits.
      rem_d  = ge ? diff[RootW:0] : cand[RootW:0];
      root_d = {root_q[RootW-2:0], ge};
      rad_d  = {rad_q[RadW-3:0], 2'b00};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == RootCntW'(RootSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> rtl/core/pmg_lane.sv
// One axis of the body: holds position, velocity and acceleration and runs the
// per-axis attract, advance and place arithmetic. Depends on pmg_pkg and pmg_divider.
`default_nettype none

module pmg_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pmg_pkg::lane_op_e                 op_i,
  input  wire logic signed [pmg_pkg::ValueW-1:0] other_i,
  input  wire logic [pmg_pkg::RootW-1:0]         root_i,
  input  wire logic [63:0]                       pull_i,
  input  wire logic [pmg_pkg::ValueW-1:0]        time_step_i,
  output pmg_pkg::lane_stat_t                    stat_o,
  output logic [2*pmg_pkg::Quo10W-1:0]           sq_o,
  output logic signed [pmg_pkg::ValueW-1:0]      pos_o,
  output logic signed [pmg_pkg::ValueW-1:0]      vel_o,
  output logic signed [pmg_pkg::ValueW-1:0]      acc_o
);
  import pmg_pkg::*;

  logic [ValueW-1:0]   pos_q, pos_d, vel_q, vel_d, acc_q, acc_d;
  logic                sat_q, sat_d;
  logic [ValueW-1:0]   dmag_q, dmag_d;
  logic                dneg_q, dneg_d;
  logic [Quo10W-1:0]   q_q, q_d;
  logic [2*Quo10W-1:0] sq_q, sq_d;
  logic [63:0]         p0_q, p0_d, p1_q, p1_d;
  logic [64:0]         afull_q, afull_d;
  logic [63:0]         atp_q, atp_d, vtp_q, vtp_d, hlo_q, hlo_d;
  logic [47:0]         hhi_q, hhi_d;

  logic [32:0]         diff;
  logic [32:0]         diff_mag;
  logic [63:0]         div10_prod;
  logic [96:0]         pull_sum;
  logic [ClampW-1:0]   acc_wide;
  logic [ValueW-1:0]   amag, vmag;
  logic [47:0]         at, vt;
  logic [79:0]         half_sum;
  logic [62:0]         half;
  logic [ClampW-1:0]   at_wide, vt_wide, half_wide;
  logic [ClampW-1:0]   nv_wide, np_wide;
  clamp_t              acc_cl, nv_cl, np_cl;
  logic                udiv_busy;
  logic [63:0]         udiv_quo;
  logic [32:0]         u;

  pmg_divider u_udiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(op_i == LOP_UDIV),
    .num_i  ({3'b000, q_q, 32'd0}),
    .den_i  ({30'd0, root_i}),
    .busy_o (udiv_busy),
    .quo_o  (udiv_quo)
  );

  always_comb begin
    diff       = {other_i[ValueW-1], other_i} - {pos_q[ValueW-1], pos_q};
    diff_mag   = diff[32] ? (33'd0 - diff) : diff;
    div10_prod = 64'(dmag_q) * 64'(Div10Magic);
    // The direction ratio never exceeds one, so the quotient has 33 bits.
    u          = udiv_quo[32:0];
    pull_sum   = 97'(p0_q) + {1'b0, p1_q, 32'd0} + (u[32] ? {1'b0, pull_i, 32'd0} : 97'd0);
    acc_wide   = dneg_q ? (ClampW'(0) - {1'b0, afull_q}) : {1'b0, afull_q};
    acc_cl     = clamp32(acc_wide);

    amag       = acc_q[ValueW-1] ? (ValueW'(0) - acc_q) : acc_q;
    vmag       = vel_q[ValueW-1] ? (ValueW'(0) - vel_q) : vel_q;
    at         = atp_q[63:FracBits];
    vt         = vtp_q[63:FracBits];
    at_wide    = ClampW'(at);
    vt_wide    = ClampW'(vt);
    half_sum   = 80'(hlo_q) + {hhi_q, 32'd0};
    half       = half_sum[79:FracBits+1];
    half_wide  = ClampW'(half);
    nv_wide    = {{(ClampW-ValueW){vel_q[ValueW-1]}}, vel_q}
               + (acc_q[ValueW-1] ? (ClampW'(0) - at_wide) : at_wide);
    np_wide    = {{(ClampW-ValueW){pos_q[ValueW-1]}}, pos_q}
               + (vel_q[ValueW-1] ? (ClampW'(0) - vt_wide) : vt_wide)
               + (acc_q[ValueW-1] ? (ClampW'(0) - half_wide) : half_wide);
    nv_cl      = clamp32(nv_wide);
    np_cl      = clamp32(np_wide);

    pos_d   = pos_q;
    vel_d   = vel_q;
    acc_d   = acc_q;
    sat_d   = sat_q;
    dmag_d  = dmag_q;
    dneg_d  = dneg_q;
    q_d     = q_q;
    sq_d    = sq_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    afull_d = afull_q;
    atp_d   = atp_q;
    vtp_d   = vtp_q;
    hlo_d   = hlo_q;
    hhi_d   = hhi_q;

    unique case (op_i)
      LOP_DIFF: begin
        dmag_d = diff_mag[ValueW-1:0];
        dneg_d = diff[32];
        sat_d  = 1'b0;
      end
      LOP_DIV10: q_d   = div10_prod[63:Div10Shift];
      LOP_SQ:    sq_d  = (2*Quo10W)'(q_q) * (2*Quo10W)'(q_q);
      LOP_MUL0:  p0_d  = 64'(pull_i[31:0]) * 64'(u[31:0]);
      LOP_MUL1:  p1_d  = 64'(pull_i[63:32]) * 64'(u[31:0]);
      LOP_MUL2:  afull_d = pull_sum[96:32];
      LOP_CLAMP: begin
        acc_d = acc_cl.val;
        sat_d = sat_q | acc_cl.sat;
      end
      LOP_ADV0: begin
        atp_d = 64'(amag) * 64'(time_step_i);
        sat_d = 1'b0;
      end
      LOP_ADV1: begin
        vel_d = nv_cl.val;
        sat_d = sat_q | nv_cl.sat;
        hlo_d = 64'(at[31:0]) * 64'(time_step_i);
        hhi_d = 48'(at[47:32]) * 48'(time_step_i);
      end
      LOP_ADV2: vtp_d = 64'(vmag) * 64'(time_step_i);
      LOP_ADV3: begin
        pos_d = np_cl.val;
        sat_d = sat_q | np_cl.sat;
      end
      LOP_PLACE: begin
        pos_d = other_i;
        vel_d = '0;
        acc_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vel_q <= '0;
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      vel_q <= vel_d;
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dmag_q  <= dmag_d;
    dneg_q  <= dneg_d;
    q_q     <= q_d;
    sq_q    <= sq_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    afull_q <= afull_d;
    atp_q   <= atp_d;
    vtp_q   <= vtp_d;
    hlo_q   <= hlo_d;
    hhi_q   <= hhi_d;
  end

  assign stat_o.busy = udiv_busy;
  assign stat_o.sat  = sat_q;
  assign sq_o        = sq_q;
  assign pos_o       = pos_q;
  assign vel_o       = vel_q;
  assign acc_o       = acc_q;

endmodule

`default_nettype wire

>>> rtl/core/point_mass_gravity_step.sv
// Top level of the point-mass gravity step: sequencer, two axis lanes, shared root
// and pull divider, and the result register. Depends on pmg_pkg, pmg_if and all units.
//
//   channel   dir  handshake      payload
//   item_i    in   valid/ready    action, other_x, other_y, other_mass
//   result_o  out  valid/ready    pos/vel/acc x and y, coincident, saturated
//   cfg_i     in   valid/ready    data (time_step), always ready
//
// Attract runs a 30-step square root, then the 64-step direction divider in the lanes,
// which outlasts the 64-step pull divider started with the root.
// A zero-distance attract stops at the distance check; an unused action goes straight to the result.
// One item is worked on at a time; a new item is taken while a result waits.
// Reset clears the body state to zero and sets time_step to one.
`default_nettype none

module point_mass_gravity_step (
  input wire logic clk_i,
  input wire logic rst_ni,
  pmg_in_if.sink   item_i,
  pmg_out_if.source result_o,
  pmg_cfg_if.sink  cfg_i
);
  import pmg_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_DIFF  = 18'h00002,
    ST_DIV10 = 18'h00004,
    ST_SQ    = 18'h00008,
    ST_SUM   = 18'h00010,
    ST_CHECK = 18'h00020,
    ST_ROOT  = 18'h00040,
    ST_QUOT  = 18'h00080,
    ST_MUL0  = 18'h00100,
    ST_MUL1  = 18'h00200,
    ST_MUL2  = 18'h00400,
    ST_CLAMP = 18'h00800,
    ST_ADV0  = 18'h01000,
    ST_ADV1  = 18'h02000,
    ST_ADV2  = 18'h04000,
    ST_ADV3  = 18'h08000,
    ST_PLACE = 18'h10000,
    ST_DONE  = 18'h20000
  } state_e;

  state_e              state_q, state_d;
  logic [1:0]          act_q, act_d;
  logic [ValueW-1:0]   ox_q, ox_d, oy_q, oy_d, mass_q, mass_d;
  logic [2*Quo10W:0]   s_q, s_d;
  logic                coin_q, coin_d;
  logic [ValueW-1:0]   time_step_q;
  logic                out_valid_q, out_valid_d;
  logic [ValueW-1:0]   out_px_q, out_py_q, out_vx_q, out_vy_q, out_ax_q, out_ay_q;
  logic                out_coin_q, out_sat_q;

  lane_op_e            lane_op;
  lane_stat_t          stat_x, stat_y;
  logic [2*Quo10W-1:0] sq_x, sq_y;
  logic [ValueW-1:0]   pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic                item_xfer, out_load, solve_start;
  logic                root_busy, pull_busy;
  logic [RootW-1:0]    root;
  logic [63:0]         pull;

  assign item_xfer   = item_i.valid && item_i.ready;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);
  assign solve_start = (state_q == ST_CHECK) && (s_q != '0);

  pmg_isqrt u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(solve_start),
    .rad_i  (RadW'(s_q)),
    .busy_o (root_busy),
    .root_o (root)
  );

  // Pull magnitude M / |d|^2 in Q16.16.
  pmg_divider u_pull (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(solve_start),
    .num_i  ({mass_q, 32'd0}),
    .den_i  (60'(s_q)),
    .busy_o (pull_busy),
    .quo_o  (pull)
  );

  pmg_lane u_lane_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (lane_op),
    .other_i    (ox_q),
    .root_i     (root),
    .pull_i     (pull),
    .time_step_i(time_step_q),
    .stat_o     (stat_x),
    .sq_o       (sq_x),
    .pos_o      (pos_x),
    .vel_o      (vel_x),
    .acc_o      (acc_x)
  );

  pmg_lane u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (lane_op),
    .other_i    (oy_q),
    .root_i     (root),
    .pull_i     (pull),
    .time_step_i(time_step_q),
    .stat_o     (stat_y),
    .sq_o       (sq_y),
    .pos_o      (pos_y),
    .vel_o      (vel_y),
    .acc_o      (acc_y)
  );

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    mass_d  = mass_q;
    s_d     = s_q;
    coin_d  = coin_q;
    lane_op = LOP_NONE;

    unique case (state_q)
      ST_IDLE: begin
        if (item_xfer) begin
          act_d  = item_i.action;
          ox_d   = item_i.other_x;
          oy_d   = item_i.other_y;
          mass_d = item_i.other_mass;
          coin_d = 1'b0;
          unique case (item_i.action)
            ACT_ATTRACT: state_d = ST_DIFF;
            ACT_ADVANCE: state_d = ST_ADV0;
            ACT_PLACE:   state_d = ST_PLACE;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_DIFF: begin
        lane_op = LOP_DIFF;
        state_d = ST_DIV10;
      end
      ST_DIV10: begin
        lane_op = LOP_DIV10;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        lane_op = LOP_SQ;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        s_d     = (2*Quo10W+1)'(sq_x) + (2*Quo10W+1)'(sq_y);
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (s_q == '0) begin
          coin_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (!root_busy) begin
          lane_op = LOP_UDIV;
          state_d = ST_QUOT;
        end
      end
      ST_QUOT: begin
        if (!pull_busy && !stat_x.busy && !stat_y.busy) begin
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        lane_op = LOP_MUL0;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        lane_op = LOP_MUL1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        lane_op = LOP_MUL2;
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        lane_op = LOP_CLAMP;
        state_d = ST_DONE;
      end
      ST_ADV0: begin
        lane_op = LOP_ADV0;
        state_d = ST_ADV1;
      end
      ST_ADV1: begin
        lane_op = LOP_ADV1;
        state_d = ST_ADV2;
      end
      ST_ADV2: begin
        lane_op = LOP_ADV2;
        state_d = ST_ADV3;
      end
      ST_ADV3: begin
        lane_op = LOP_ADV3;
        state_d = ST_DONE;
      end
      ST_PLACE: begin
        lane_op = LOP_PLACE;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      coin_q      <= 1'b0;
      out_valid_q <= 1'b0;
      time_step_q <= TimeStepReset;
    end else begin
      state_q     <= state_d;
      coin_q      <= coin_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        time_step_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    mass_q <= mass_d;
    s_q    <= s_d;
    if (out_load) begin
      out_px_q   <= pos_x;
      out_py_q   <= pos_y;
      out_vx_q   <= vel_x;
      out_vy_q   <= vel_y;
      out_ax_q   <= acc_x;
      out_ay_q   <= acc_y;
      out_coin_q <= coin_q;
      // Lane flags are only meaningful for attract and advance transfers.
      out_sat_q  <= ((act_q == ACT_ATTRACT) || (act_q == ACT_ADVANCE))
                    && (stat_x.sat || stat_y.sat);
    end
  end

  assign item_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign result_o.valid     = out_valid_q;
  assign result_o.pos_x     = out_px_q;
  assign result_o.pos_y     = out_py_q;
  assign result_o.vel_x     = out_vx_q;
  assign result_o.vel_y     = out_vy_q;
  assign result_o.acc_x     = out_ax_q;
  assign result_o.acc_y     = out_ay_q;
  assign result_o.coincident = out_coin_q;
  assign result_o.saturated = out_sat_q;

  a_item_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_xfer |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after an item transfer");

  a_solver_free_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    solve_start |-> !root_busy && !pull_busy)
    else $error("root or pull unit restarted while busy");

  a_mul_after_dividers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL0 |-> !pull_busy && !stat_x.busy && !stat_y.busy)
    else $error("multiply began before the dividers finished");

  a_coincident_unclamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.coincident |-> !result_o.saturated)
    else $error("zero-distance result reported saturation");

endmodule

`default_nettype wire

>>> test/point_mass_gravity_step_tb.sv
// Self-checking testbench of the point-mass gravity step: random items and idling on
// all channels, checked against a predictor of the body state kept in this module.
// Depends on pmg_pkg, the pmg channel interfaces and the point_mass_gravity_step RTL.
`default_nettype none

module point_mass_gravity_step_tb;
  import pmg_pkg::*;

  localparam int          CycleLimit = 2_000_000;
  localparam int          SettleWait = 150;
  localparam logic [1:0]  ActUnused  = 2'd3;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] mass;
  } body_item_t;

  typedef struct {
    logic [31:0] px, py, vx, vy, ax, ay;
    logic        coin, sat;
  } body_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pmg_in_if  item_bus ();
  pmg_out_if result_bus ();
  pmg_cfg_if cfg_bus ();

  point_mass_gravity_step DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  always #4 clk_i = ~clk_i;

  // Predicted body state and time step.
  logic signed [31:0] body_px, body_py, body_vx, body_vy, body_ax, body_ay;
  logic [31:0]        step_dt;

  body_item_t  pending_items[$];
  body_state_t expected_states[$];

  int unsigned cycle_count = 0;
  int unsigned items_offered = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned n_attract = 0, n_advance = 0, n_place = 0, n_unused = 0;
  int unsigned n_coincident = 0, n_saturated = 0, n_dt_settings = 0;
  int unsigned item_gap = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b1;
  bit          long_hold_req = 1'b0;

  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    return (p[127:64] != '0) ? '1 : p[63:0];
  endfunction

  function automatic longint capped_signed(bit neg, logic [63:0] mag);
    if (mag > 64'h4000_0000_0000_0000) mag = 64'h4000_0000_0000_0000;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [31:0] clamp_word(logic signed [71:0] v, inout bit sat);
    if (v > 72'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -72'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] pull_axis(longint d, logic [63:0] g, logic [63:0] r,
                                            inout bit sat);
    logic [63:0]        u;
    logic signed [71:0] w;
    u = (magnitude(d) << 32) / r;
    w = capped_signed(d < 0, scaled_product(g, u, 32));
    return clamp_word(w, sat);
  endfunction

  function automatic void advance_axis(inout logic signed [31:0] p,
                                       inout logic signed [31:0] v,
                                       input logic signed [31:0] a, inout bit sat);
    logic [63:0]        at, vt, half;
    logic signed [71:0] w;
    at = scaled_product(magnitude(a), {32'b0, step_dt}, FracBits);
    w = v + capped_signed(a < 0, at);
    v = clamp_word(w, sat);
    vt = scaled_product(magnitude(v), {32'b0, step_dt}, FracBits);
    half = scaled_product(at, {32'b0, step_dt}, FracBits + 1);
    w = p;
    w = w + capped_signed(v < 0, vt) + capped_signed(a < 0, half);
    p = clamp_word(w, sat);
  endfunction

  // Applies one item to the predicted body and returns the state after it.
  function automatic body_state_t step_body(body_item_t it);
    body_state_t res;
    bit          coin, sat;
    longint      dx, dy;
    logic [63:0] mx, my, s, r, g;
    coin = 1'b0;
    sat = 1'b0;
    case (it.action)
      ACT_ATTRACT: begin
        dx = (longint'(signed'(it.ox)) - longint'(body_px)) / 10;
        dy = (longint'(signed'(it.oy)) - longint'(body_py)) / 10;
        mx = magnitude(dx);
        my = magnitude(dy);
        s = mx * mx + my * my;
        if (s == 0) begin
          coin = 1'b1;
        end else begin
          r = root_floor(s);
          g = {it.mass, 32'b0} / s;
          body_ax = pull_axis(dx, g, r, sat);
          body_ay = pull_axis(dy, g, r, sat);
        end
      end
      ACT_ADVANCE: begin
        advance_axis(body_px, body_vx, body_ax, sat);
        advance_axis(body_py, body_vy, body_ay, sat);
      end
      ACT_PLACE: begin
        body_px = it.ox;
        body_py = it.oy;
        body_vx = '0;
        body_vy = '0;
        body_ax = '0;
        body_ay = '0;
      end
      default: ;
    endcase
    res.px = body_px;
    res.py = body_py;
    res.vx = body_vx;
    res.vy = body_vy;
    res.ax = body_ax;
    res.ay = body_ay;
    res.coin = coin;
    res.sat = sat;
    return res;
  endfunction

  task automatic queue_item(logic [1:0] action, logic [31:0] ox, logic [31:0] oy,
                            logic [31:0] mass);
    body_item_t it;
    it.action = action;
    it.ox = ox;
    it.oy = oy;
    it.mass = mass;
    pending_items.push_back(it);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(20, 4);
    return $urandom_range(150, 30);
  endfunction

  // Positions mostly within a few hundred units so that attracts and advances stay
  // meaningful; now and then the full range.
  function automatic logic [31:0] pick_coord();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(32'h0400_0000) - 32'h0200_0000;
  endfunction

  task automatic queue_random(int unsigned count);
    logic [31:0] mass;
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      mass = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF);
      if (roll < 10) begin
        queue_item(ACT_PLACE, pick_coord(), pick_coord(), $urandom);
      end else if (roll < 50) begin
        queue_item(ACT_ATTRACT, pick_coord(), pick_coord(), mass);
      end else if (roll < 85) begin
        queue_item(ACT_ADVANCE, $urandom, $urandom, $urandom);
      end else begin
        queue_item(2'($urandom_range(3)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic write_time_step(logic [31:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && items_taken == items_offered &&
          expected_states.size() == 0);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // Accepted items and configuration writes update the predictor at the same edge.
  always @(posedge clk_i) begin
    body_item_t it;
    if (rst_ni && cfg_bus.valid && cfg_bus.ready) begin
      step_dt = cfg_bus.data;
      n_dt_settings++;
    end
    if (rst_ni && item_bus.valid && item_bus.ready) begin
      it.action = item_bus.action;
      it.ox = item_bus.other_x;
      it.oy = item_bus.other_y;
      it.mass = item_bus.other_mass;
      case (it.action)
        ACT_ATTRACT: n_attract++;
        ACT_ADVANCE: n_advance++;
        ACT_PLACE:   n_place++;
        default:     n_unused++;
      endcase
      expected_states.push_back(step_body(it));
      items_taken++;
    end
  end

  always @(negedge clk_i) begin
    body_item_t it;
    if (rst_ni && (!item_bus.valid || items_taken == items_offered)) begin
      if (item_gap > 0) begin
        item_gap--;
        item_bus.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        item_bus.action <= it.action;
        item_bus.other_x <= it.ox;
        item_bus.other_y <= it.oy;
        item_bus.other_mass <= it.mass;
        item_bus.valid <= 1'b1;
        items_offered++;
        item_gap = pick_gap();
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // Result acceptance, with its own count of stall cycles.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      result_bus.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = 600;
      result_bus.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      result_bus.ready <= (stall_left == 0);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    body_state_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (expected_states.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no item pending, expected none actual pos %h,%h",
                 $time, result_bus.pos_x, result_bus.pos_y);
      end else begin
        want = expected_states.pop_front();
        check_field("pos_x", want.px, result_bus.pos_x);
        check_field("pos_y", want.py, result_bus.pos_y);
        check_field("vel_x", want.vx, result_bus.vel_x);
        check_field("vel_y", want.vy, result_bus.vel_y);
        check_field("acc_x", want.ax, result_bus.acc_x);
        check_field("acc_y", want.ay, result_bus.acc_y);
        check_field("coincident", 32'(want.coin), 32'(result_bus.coincident));
        check_field("saturated", 32'(want.sat), 32'(result_bus.saturated));
        if (result_bus.coincident) n_coincident++;
        if (result_bus.saturated) n_saturated++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_states.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] dt_list[7];
    item_bus.valid = 1'b0;
    item_bus.action = '0;
    item_bus.other_x = '0;
    item_bus.other_y = '0;
    item_bus.other_mass = '0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    body_px = '0;
    body_py = '0;
    body_vx = '0;
    body_vy = '0;
    body_ax = '0;
    body_ay = '0;
    step_dt = TimeStepReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_time_step(32'h0001_0000);
    // Directed: a pull from the right, integration, a coincident attract, extremes.
    queue_item(ACT_ATTRACT, 32'h0064_0000, 32'h0, 32'h0001_0000);
    queue_item(ACT_ADVANCE, 32'h0, 32'h0, 32'h0);
    queue_item(ACT_ATTRACT, 32'h0000_0009, 32'hFFFF_FFF7, 32'hFFFF_FFFF);
    queue_item(ACT_ATTRACT, 32'h0, 32'hFF9C_0000, 32'h0);
    queue_item(ACT_PLACE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_item(ACT_ATTRACT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_item(ACT_ATTRACT, 32'h7FFF_FFFF, 32'h8000_000A, 32'hFFFF_FFFF);
    queue_item(ACT_ATTRACT, 32'h7FFF_FFF5, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_item(ACT_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(ActUnused, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
    queue_item(ACT_PLACE, 32'h0, 32'h0, 32'h0);
    queue_item(ACT_ATTRACT, 32'h0000_000A, 32'h0, 32'hFFFF_FFFF);
    queue_item(ACT_ADVANCE, 32'h0, 32'h0, 32'h0);
    queue_item(ACT_ADVANCE, 32'h0, 32'h0, 32'h0);
    queue_item(ACT_ATTRACT, 32'hFFFF_FFF6, 32'h0000_000A, 32'h0000_0001);
    queue_item(ACT_ADVANCE, 32'h0, 32'h0, 32'h0);
    queue_item(ActUnused, 32'h0, 32'h0, 32'h0);
    queue_item(ACT_PLACE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    queue_item(ACT_ATTRACT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    queue_item(ACT_ATTRACT, 32'h0, 32'h0, 32'h0100_0000);
    queue_item(ACT_ADVANCE, 32'h0, 32'h0, 32'h0);
    drain();

    dt_list = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_8000, 32'h0001_0000,
                32'h0002_0000, $urandom};
    for (int i = 0; i < 7; i++) begin
      write_time_step(dt_list[i]);
      gaps_on = (i != 3);
      if (i == 3) long_hold_req = 1'b1;
      queue_random(155);
      drain();
    end

    $display("Run covered %0d attract, %0d advance, %0d place, %0d unused items; %0d dt values.",
             n_attract, n_advance, n_place, n_unused, n_dt_settings);
    $display("%0d results checked, %0d coincident, %0d saturated.",
             results_seen, n_coincident, n_saturated);
    if (mismatch_count == 0 && expected_states.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
